### design/wdv_pkg.sv
// Shared types and command codes of the weighted difference variance core.
package wdv_pkg;

	localparam logic [1:0] CMD_ADD    = 2'd0;
	localparam logic [1:0] CMD_MERGE  = 2'd1;
	localparam logic [1:0] CMD_REPORT = 2'd2;
	localparam logic [1:0] CMD_CLEAR  = 2'd3;

	typedef struct packed {
		logic [1:0]         command;
		logic signed [31:0] value_a;
		logic signed [31:0] value_b;
		logic [31:0]        jacobian_weight;
		logic [31:0]        coord_factor;
		logic signed [31:0] other_mean;
		logic [63:0]        other_sum_squares;
		logic [47:0]        other_weight_sum;
		logic [63:0]        other_weight_square_sum;
	} item_t;

	typedef struct packed {
		logic signed [31:0] mean;
		logic [47:0]        variance;
		logic               variance_valid;
	} result_t;

	typedef struct packed {
		logic [3:0] kind;
		item_t      item;
	} entry_t;

	typedef struct packed {
		logic        go;
		logic [63:0] a;
		logic [63:0] b;
	} mul_req_t;

	typedef struct packed {
		logic        go;
		logic [63:0] hi;
		logic [63:0] lo;
		logic [63:0] d;
	} div_req_t;

endpackage

### design/wdv_front.sv
// Input side: accepts words into a two-entry queue and classifies each command.
module wdv_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_stall,
	input  wdv_pkg::item_t item,
	input  logic           pop,
	output logic           avail,
	output wdv_pkg::entry_t head
);
	import wdv_pkg::*;

	entry_t     mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       take;

	assign item_stall = (cnt_q == 2'd2);
	assign avail      = (cnt_q != 2'd0);
	assign head       = mem_q[rd_q];
	assign push       = item_valid && !item_stall;
	assign take       = pop && avail;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q].kind <= 4'b0001 << item.command;
			mem_q[wr_q].item <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= !wr_q;
			if (take)
				rd_q <= !rd_q;
			if (push && !take)
				cnt_q <= cnt_q + 2'd1;
			else if (take && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule

### design/wdv_mul.sv
// Shared 64 by 64 multiplier working one 16-bit digit of b per cycle.
module wdv_mul (
	input  logic               clk,
	input  logic               arst_n,
	input  wdv_pkg::mul_req_t  req,
	output logic               done,
	output logic [127:0]       prod
);
	import wdv_pkg::*;

	logic [63:0]  a_q;
	logic [63:0]  b_q;
	logic [127:0] acc_q;
	logic [2:0]   cnt_q;
	logic         busy_q;
	logic         done_q;
	logic [79:0]  pp;

	assign pp   = a_q * b_q[63:48];
	assign done = done_q;
	assign prod = acc_q;

	always_ff @(posedge clk) begin
		if (req.go) begin
			a_q   <= req.a;
			b_q   <= req.b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= {acc_q[111:0], 16'd0} + {48'd0, pp};
			b_q   <= {b_q[47:0], 16'd0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 3'd0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				busy_q <= 1'b1;
				cnt_q  <= 3'd4;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 3'd1;
				if (cnt_q == 3'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

### design/wdv_div.sv
// Shared 128 by 64 restoring divider, one quotient bit per cycle, saturating.
module wdv_div (
	input  logic              clk,
	input  logic              arst_n,
	input  wdv_pkg::div_req_t req,
	output logic              done,
	output logic [63:0]       quo
);
	import wdv_pkg::*;

	logic [63:0] rem_q;
	logic [63:0] lo_q;
	logic [63:0] d_q;
	logic [63:0] quo_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [64:0] t;
	logic [64:0] t_sub;
	logic        bit_ok;

	assign t      = {rem_q, lo_q[63]};
	assign bit_ok = (t >= {1'b0, d_q});
	assign t_sub  = t - {1'b0, d_q};
	assign done   = done_q;
	assign quo    = quo_q;

	always_ff @(posedge clk) begin
		if (req.go) begin
			rem_q <= req.hi;
			lo_q  <= req.lo;
			d_q   <= req.d;
			quo_q <= (req.d == 64'd0 || req.hi >= req.d) ? '1 : '0;
		end else if (busy_q) begin
			rem_q <= bit_ok ? t_sub[63:0] : t[63:0];
			lo_q  <= {lo_q[62:0], 1'b0};
			quo_q <= {quo_q[62:0], bit_ok};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 7'd0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				if (req.d == 64'd0 || req.hi >= req.d) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= 7'd64;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

### design/wdv_back.sv
// Execution side: sequences add, merge, report and clear on the shared units.
module wdv_back #(
	parameter int FRACTION_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              avail,
	input  wdv_pkg::entry_t   head,
	output logic              pop,
	output wdv_pkg::mul_req_t mul_req,
	input  logic              mul_done,
	input  logic [127:0]      mul_prod,
	output wdv_pkg::div_req_t div_req,
	input  logic              div_done,
	input  logic [63:0]       div_quo,
	output logic              result_valid,
	input  logic              result_stall,
	output wdv_pkg::result_t  result
);
	import wdv_pkg::*;

	localparam logic [4:0] ST_IDLE = 5'd0;
	localparam logic [4:0] ST_ADD0 = 5'd1;
	localparam logic [4:0] ST_ADD1 = 5'd2;
	localparam logic [4:0] ST_ADD2 = 5'd3;
	localparam logic [4:0] ST_ADD3 = 5'd4;
	localparam logic [4:0] ST_ADD4 = 5'd5;
	localparam logic [4:0] ST_ADD5 = 5'd6;
	localparam logic [4:0] ST_ADD6 = 5'd7;
	localparam logic [4:0] ST_ADD7 = 5'd8;
	localparam logic [4:0] ST_MRG0 = 5'd9;
	localparam logic [4:0] ST_MRG1 = 5'd10;
	localparam logic [4:0] ST_MRG2 = 5'd11;
	localparam logic [4:0] ST_MRG3 = 5'd12;
	localparam logic [4:0] ST_MRG4 = 5'd13;
	localparam logic [4:0] ST_MRG5 = 5'd14;
	localparam logic [4:0] ST_MRG6 = 5'd15;
	localparam logic [4:0] ST_RPT0 = 5'd16;
	localparam logic [4:0] ST_RPT1 = 5'd17;
	localparam logic [4:0] ST_RPT2 = 5'd18;
	localparam logic [4:0] ST_ROUT = 5'd19;
	localparam logic [4:0] ST_CLR  = 5'd20;

	localparam logic [47:0] MAX48 = '1;
	localparam logic [63:0] MAX64 = '1;

	logic [4:0]         state_q;
	item_t              cur_q;
	logic signed [31:0] mean_q;
	logic [63:0]        s_q;
	logic [47:0]        w_q;
	logic [63:0]        w2_q;
	logic [63:0]        wprod_q;
	logic [47:0]        wt_q;
	logic [47:0]        tot_q;
	logic signed [32:0] d_q;
	logic signed [33:0] dlt_q;
	logic signed [31:0] nm_q;
	logic [63:0]        p_q;
	logic [63:0]        os_q;
	mul_req_t           mul_q;
	div_req_t           div_q;
	result_t            rpt_q;
	result_t            res_q;
	logic               res_valid_q;

	logic signed [32:0] d_in;
	logic signed [33:0] dlt_add;
	logic signed [33:0] dlt_mrg;
	logic signed [33:0] dn;
	logic [63:0]        w_full;
	logic [47:0]        w_in;
	logic [47:0]        tot_add;
	logic [47:0]        tot_mrg;
	logic [63:0]        frac;
	logic signed [31:0] moved;
	logic [63:0]        w2_sh_hi;
	logic [63:0]        w2_sh_lo;
	logic [63:0]        s_sh_hi;
	logic [63:0]        s_sh_lo;

	function automatic logic [63:0] shr_frac(input logic [127:0] x);
		if (|x[127:64+FRACTION_BITS])
			return '1;
		return x[63+FRACTION_BITS:FRACTION_BITS];
	endfunction

	function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? MAX64 : s[63:0];
	endfunction

	function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [47:0] b);
		logic [48:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[48] ? MAX48 : s[47:0];
	endfunction

	function automatic logic [63:0] abs34(input logic signed [33:0] v);
		logic [33:0] m;
		m = v[33] ? 34'(-v) : 34'(v);
		return {30'd0, m};
	endfunction

	function automatic logic signed [31:0] step_mean(input logic signed [31:0] base,
			input logic neg, input logic [63:0] q);
		logic signed [36:0] s;
		s = neg ? ({{5{base[31]}}, base} - $signed({2'b00, q[34:0]}))
		        : ({{5{base[31]}}, base} + $signed({2'b00, q[34:0]}));
		if (s > 37'sd2147483647)
			return 32'sh7fffffff;
		if (s < -37'sd2147483648)
			return 32'sh80000000;
		return s[31:0];
	endfunction

	assign d_in     = {cur_q.value_a[31], cur_q.value_a} - {cur_q.value_b[31], cur_q.value_b};
	assign dlt_add  = {d_in[32], d_in} - {{2{mean_q[31]}}, mean_q};
	assign dlt_mrg  = {{2{cur_q.other_mean[31]}}, cur_q.other_mean} - {{2{mean_q[31]}}, mean_q};
	assign dn       = {d_q[32], d_q} - {{2{nm_q[31]}}, nm_q};
	assign w_full   = wprod_q >> FRACTION_BITS;
	assign w_in     = (|w_full[63:48]) ? MAX48 : w_full[47:0];
	assign tot_add  = sat_add48(w_q, w_in);
	assign tot_mrg  = sat_add48(w_q, cur_q.other_weight_sum);
	assign frac     = shr_frac(mul_prod);
	assign moved    = step_mean(mean_q, dlt_q[33], div_quo);
	assign w2_sh_hi = w2_q >> (64 - FRACTION_BITS);
	assign w2_sh_lo = w2_q << FRACTION_BITS;
	assign s_sh_hi  = s_q >> (64 - FRACTION_BITS);
	assign s_sh_lo  = s_q << FRACTION_BITS;

	assign pop          = (state_q == ST_IDLE) && avail;
	assign mul_req      = mul_q;
	assign div_req      = div_q;
	assign result_valid = res_valid_q;
	assign result       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mean_q      <= '0;
			s_q         <= '0;
			w_q         <= '0;
			w2_q        <= '0;
			mul_q       <= '0;
			div_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			mul_q.go <= 1'b0;
			div_q.go <= 1'b0;
			if (state_q == ST_ROUT && (!res_valid_q || !result_stall))
				res_valid_q <= 1'b1;
			else if (res_valid_q && !result_stall)
				res_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (avail) begin
						cur_q <= head.item;
						if (head.kind[CMD_ADD])
							state_q <= ST_ADD0;
						else if (head.kind[CMD_MERGE])
							state_q <= ST_MRG0;
						else if (head.kind[CMD_REPORT])
							state_q <= ST_RPT0;
						else
							state_q <= ST_CLR;
					end
				end
				ST_ADD0: begin
					wprod_q <= cur_q.jacobian_weight * cur_q.coord_factor;
					state_q <= ST_ADD1;
				end
				ST_ADD1: begin
					wt_q  <= w_in;
					tot_q <= tot_add;
					d_q   <= d_in;
					dlt_q <= dlt_add;
					if (tot_add == 48'd0) begin
						state_q <= ST_IDLE;
					end else begin
						mul_q <= '{go: 1'b1, a: abs34(dlt_add), b: {16'd0, w_in}};
						state_q <= ST_ADD2;
					end
				end
				ST_ADD2: begin
					if (mul_done) begin
						div_q <= '{go: 1'b1, hi: mul_prod[127:64], lo: mul_prod[63:0],
							d: {16'd0, tot_q}};
						state_q <= ST_ADD3;
					end
				end
				ST_ADD3: begin
					if (div_done) begin
						nm_q    <= moved;
						state_q <= ST_ADD4;
					end
				end
				ST_ADD4: begin
					mul_q   <= '{go: 1'b1, a: abs34(dlt_q), b: abs34(dn)};
					state_q <= ST_ADD5;
				end
				ST_ADD5: begin
					if (mul_done) begin
						mul_q   <= '{go: 1'b1, a: {16'd0, wt_q}, b: frac};
						state_q <= ST_ADD6;
					end
				end
				ST_ADD6: begin
					if (mul_done) begin
						s_q     <= sat_add64(s_q, frac);
						mul_q   <= '{go: 1'b1, a: {16'd0, wt_q}, b: {16'd0, wt_q}};
						state_q <= ST_ADD7;
					end
				end
				ST_ADD7: begin
					if (mul_done) begin
						w2_q    <= sat_add64(w2_q, frac);
						w_q     <= tot_q;
						mean_q  <= nm_q;
						state_q <= ST_IDLE;
					end
				end
				ST_MRG0: begin
					tot_q <= tot_mrg;
					dlt_q <= dlt_mrg;
					os_q  <= cur_q.other_sum_squares;
					if (tot_mrg == 48'd0) begin
						s_q     <= sat_add64(s_q, cur_q.other_sum_squares);
						w2_q    <= sat_add64(w2_q, cur_q.other_weight_square_sum);
						state_q <= ST_IDLE;
					end else begin
						mul_q   <= '{go: 1'b1, a: abs34(dlt_mrg), b: abs34(dlt_mrg)};
						state_q <= ST_MRG1;
					end
				end
				ST_MRG1: begin
					if (mul_done) begin
						p_q     <= frac;
						mul_q   <= '{go: 1'b1, a: {16'd0, w_q}, b: {16'd0, cur_q.other_weight_sum}};
						state_q <= ST_MRG2;
					end
				end
				ST_MRG2: begin
					if (mul_done) begin
						div_q <= '{go: 1'b1, hi: mul_prod[127:64], lo: mul_prod[63:0],
							d: {16'd0, tot_q}};
						state_q <= ST_MRG3;
					end
				end
				ST_MRG3: begin
					if (div_done) begin
						mul_q   <= '{go: 1'b1, a: p_q, b: div_quo};
						state_q <= ST_MRG4;
					end
				end
				ST_MRG4: begin
					if (mul_done) begin
						os_q    <= sat_add64(os_q, frac);
						mul_q   <= '{go: 1'b1, a: abs34(dlt_q), b: {16'd0, cur_q.other_weight_sum}};
						state_q <= ST_MRG5;
					end
				end
				ST_MRG5: begin
					if (mul_done) begin
						div_q <= '{go: 1'b1, hi: mul_prod[127:64], lo: mul_prod[63:0],
							d: {16'd0, tot_q}};
						state_q <= ST_MRG6;
					end
				end
				ST_MRG6: begin
					if (div_done) begin
						mean_q  <= moved;
						w_q     <= tot_q;
						s_q     <= sat_add64(s_q, os_q);
						w2_q    <= sat_add64(w2_q, cur_q.other_weight_square_sum);
						state_q <= ST_IDLE;
					end
				end
				ST_RPT0: begin
					rpt_q.mean <= mean_q;
					if (w_q == 48'd0) begin
						rpt_q.variance       <= '0;
						rpt_q.variance_valid <= 1'b0;
						state_q              <= ST_ROUT;
					end else begin
						div_q   <= '{go: 1'b1, hi: w2_sh_hi, lo: w2_sh_lo, d: {16'd0, w_q}};
						state_q <= ST_RPT1;
					end
				end
				ST_RPT1: begin
					if (div_done) begin
						if (div_quo < {16'd0, w_q}) begin
							div_q   <= '{go: 1'b1, hi: s_sh_hi, lo: s_sh_lo,
								d: {16'd0, w_q} - div_quo};
							state_q <= ST_RPT2;
						end else begin
							rpt_q.variance       <= '0;
							rpt_q.variance_valid <= 1'b0;
							state_q              <= ST_ROUT;
						end
					end
				end
				ST_RPT2: begin
					if (div_done) begin
						rpt_q.variance       <= (|div_quo[63:48]) ? MAX48 : div_quo[47:0];
						rpt_q.variance_valid <= 1'b1;
						state_q              <= ST_ROUT;
					end
				end
				ST_ROUT: begin
					if (!res_valid_q || !result_stall) begin
						res_q   <= rpt_q;
						state_q <= ST_IDLE;
					end
				end
				ST_CLR: begin
					mean_q  <= '0;
					s_q     <= '0;
					w_q     <= '0;
					w2_q    <= '0;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

### design/weighted_difference_variance_core.sv
// Top level of the weighted difference variance core.
//
// Words enter on the item channel (item_valid, item_stall, item) and wait in a
// two-entry queue; item_stall rises only when that queue is full. Add, merge and
// clear words give no result; a report word gives one word on the result channel
// (result_valid, result_stall, result) carrying the mean and the variance.
// Words are executed one at a time by a sequencer that shares one multiplier
// (16-bit digits of b) and one divider (one quotient bit per cycle). An add or
// a merge whose total weight stays zero returns to idle without using either.
// The result sits in an output register until taken; while the receiver stalls,
// the sequencer keeps going on non-report words and waits only when a second
// report is ready. Reset zeroes the accumulators and empties the queue and the
// output register.
module weighted_difference_variance_core #(
	parameter int FRACTION_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  wdv_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output wdv_pkg::result_t result
);
	import wdv_pkg::*;

	logic         pop;
	logic         avail;
	entry_t       head;
	mul_req_t     mul_req;
	logic         mul_done;
	logic [127:0] mul_prod;
	div_req_t     div_req;
	logic         div_done;
	logic [63:0]  div_quo;

	wdv_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.pop        (pop),
		.avail      (avail),
		.head       (head)
	);

	wdv_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	wdv_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quo    (div_quo)
	);

	wdv_back #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.avail        (avail),
		.head         (head),
		.pop          (pop),
		.mul_req      (mul_req),
		.mul_done     (mul_done),
		.mul_prod     (mul_prod),
		.div_req      (div_req),
		.div_done     (div_done),
		.div_quo      (div_quo),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

### design/wdv_checker.sv
// Port-level checks of the weighted difference variance core and their binding.
module wdv_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             item_valid,
	input logic             item_stall,
	input wdv_pkg::item_t   item,
	input logic             result_valid,
	input logic             result_stall,
	input wdv_pkg::result_t result
);
	import wdv_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("Result word changed while stalled.");

	a_zero_var: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.variance_valid |-> result.variance == 48'd0)
		else $error("Variance is not zero on an invalid result.");

	a_reset: assert property (@(posedge clk)
		!arst_n |=> !result_valid && !item_stall)
		else $error("Outputs not cleared during reset.");

	a_report_only: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(arst_n))
		else $error("Result word appeared straight out of reset.");

endmodule

bind weighted_difference_variance_core wdv_checker u_wdv_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.item         (item),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
